[rtl/core/ikm_pkg.sv]
// ----------------------------------------------------------------------------
// ikm_pkg
// Shared codes, state types, constants and elaboration-time helpers for the
// Ikeda map iterator.
// ----------------------------------------------------------------------------
package ikm_pkg;

   localparam int CSR_IDX_BITS = 3;
   localparam int FUNC_BITS    = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_STEP    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] REG_COEF_A  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ANGLE_B = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_K  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_PHASE_P = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_X = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_Y = 3'd5;

   localparam logic [31:0] RST_COEF_A  = 32'd14260634;
   localparam logic [31:0] RST_ANGLE_B = 32'd15099494;
   localparam logic [31:0] RST_GAIN_K  = 32'd6710886;
   localparam logic [31:0] RST_PHASE_P = 32'd129184563;

   localparam logic [63:0] PI_Q60         = 64'd3622009729038561421;
   localparam logic [63:0] QUARTER_PI_Q60 = 64'd905502432259640355;
   localparam logic [63:0] GAIN_Q32       = 64'd2608131496;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR,
      ST_DIV,
      ST_TRIG,
      ST_ROT,
      ST_GAIN
   } ikm_state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_REDUCE,
      CS_FOLD,
      CS_ROTATE
   } ikm_cord_state_type;

   function automatic logic [63:0] to_frac(input logic [63:0] v60, input int f);
      return (v60 + (64'd1 << (59 - f))) >> (60 - f);
   endfunction

   function automatic logic [63:0] gain_frac(input int f);
      if (f < 32) begin
         return (GAIN_Q32 + (64'd1 << (31 - f))) >> (32 - f);
      end
      return GAIN_Q32 << (f - 32);
   endfunction

   function automatic logic [63:0] atan_q60(input int i);
      logic signed [63:0] acc;
      logic signed [63:0] term;
      int n;
      acc = '0;
      if (i == 0) begin
         return QUARTER_PI_Q60;
      end
      for (n = 0; n < 31; n++) begin
         if (i * (2 * n + 1) <= 60) begin
            term = signed'((64'd1 << (60 - i * (2 * n + 1))) / 64'(2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
         end
      end
      return unsigned'(acc);
   endfunction

   function automatic logic [63:0] atan_frac(input int i, input int f);
      return to_frac(atan_q60(i), f);
   endfunction

endpackage

[rtl/core/ikm_if.sv]
// ----------------------------------------------------------------------------
// ikm_if
// Valid/ready channel interfaces: step requests, point responses and
// register writes.
// ----------------------------------------------------------------------------
interface ikm_req_if #(parameter int WORD_BITS = 32);
   logic                              valid;
   logic                              ready;
   logic [ikm_pkg::FUNC_BITS-1:0]     func;
   logic signed [WORD_BITS-1:0]       load_x;
   logic signed [WORD_BITS-1:0]       load_y;
   modport source (output valid, output func, output load_x, output load_y, input ready);
   modport sink (input valid, input func, input load_x, input load_y, output ready);
endinterface

interface ikm_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] out_x;
   logic signed [WORD_BITS-1:0] out_y;
   modport source (output valid, output out_x, output out_y, input ready);
   modport sink (input valid, input out_x, input out_y, output ready);
endinterface

interface ikm_csr_if #(parameter int WORD_BITS = 32);
   logic                             valid;
   logic                             ready;
   logic [ikm_pkg::CSR_IDX_BITS-1:0] index;
   logic [WORD_BITS-1:0]             data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/ikm_mul.sv]
// ----------------------------------------------------------------------------
// ikm_mul
// Shared sign-magnitude multiplier with registered product, exact and
// rounded-to-fraction results.
// ----------------------------------------------------------------------------
module ikm_mul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 24,
   localparam int MAG_BITS  = (WORD_BITS > FRAC_BITS) ? WORD_BITS + 1 : FRAC_BITS + 1,
   localparam int OP_BITS   = MAG_BITS + 1,
   localparam int PROD_BITS = 2 * MAG_BITS
) (
   input  logic                      clock,
   input  logic signed [OP_BITS-1:0] op_a,
   input  logic signed [OP_BITS-1:0] op_b,
   output logic [PROD_BITS-1:0]      prod,
   output logic signed [63:0]        prod_q
);
   logic [MAG_BITS-1:0]  mag_a;
   logic [MAG_BITS-1:0]  mag_b;
   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic [PROD_BITS:0]   rnd;
   logic [PROD_BITS:0]   rnd_sh;
   logic                 sat;
   logic [62:0]          q_mag;

   always_comb begin
      mag_a   = MAG_BITS'(op_a[OP_BITS-1] ? -op_a : op_a);
      mag_b   = MAG_BITS'(op_b[OP_BITS-1] ? -op_b : op_b);
      prod_in = PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
      neg_in  = op_a[OP_BITS-1] ^ op_b[OP_BITS-1];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      rnd    = {1'b0, prod_ff} + ((PROD_BITS + 1)'(1) << (FRAC_BITS - 1));
      sat    = (rnd >> (62 + FRAC_BITS)) != '0;
      rnd_sh = rnd >> FRAC_BITS;
      q_mag  = sat ? (63'(1) << 62) : 63'(rnd_sh);
      prod_q = neg_ff ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});
      prod   = prod_ff;
   end

endmodule

[rtl/core/ikm_div.sv]
// ----------------------------------------------------------------------------
// ikm_div
// Restoring divider, one quotient bit per cycle: |p| * 2^(2F) / denominator.
// ----------------------------------------------------------------------------
module ikm_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 24,
   localparam int DEN_BITS = ((WORD_BITS > FRAC_BITS) ? 2 * WORD_BITS : 2 * FRAC_BITS) + 1,
   localparam int ACC_BITS = DEN_BITS + WORD_BITS,
   localparam int CNT_BITS = $clog2(WORD_BITS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0]  divisor,
   output logic [WORD_BITS-1:0] quotient,
   output logic                 done
);
   logic [ACC_BITS-1:0] acc_ff;
   logic [ACC_BITS-1:0] acc_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [CNT_BITS-1:0] cnt_in;
   logic                busy_ff;
   logic                busy_in;
   logic                done_ff;
   logic                done_in;
   logic [ACC_BITS:0]   shifted;
   logic [DEN_BITS:0]   top;
   logic [DEN_BITS:0]   diff;
   logic                last;

   always_comb begin
      shifted = {acc_ff, 1'b0};
      top     = shifted[ACC_BITS:WORD_BITS];
      diff    = top - {1'b0, den_ff};
      last    = cnt_ff == CNT_BITS'(WORD_BITS - 1);
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = ACC_BITS'(dividend) << (2 * FRAC_BITS);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (top >= {1'b0, den_ff}) begin
            acc_in = {diff[DEN_BITS-1:0], shifted[WORD_BITS-1:1], 1'b1};
         end else begin
            acc_in = shifted[ACC_BITS-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         den_ff <= divisor;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = acc_ff[WORD_BITS-1:0];
   assign done     = done_ff;

endmodule

[rtl/core/ikm_cordic.sv]
// ----------------------------------------------------------------------------
// ikm_cordic
// Angle reduction by shifted compare-subtract, quadrant fold and a shared
// rotation-mode CORDIC stage giving cos and sin.
// ----------------------------------------------------------------------------
module ikm_cordic #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 24,
   localparam int T_BITS    = WORD_BITS + 2,
   localparam int X_BITS    = FRAC_BITS + 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [T_BITS-1:0] angle,
   output logic signed [X_BITS-1:0] cos_q,
   output logic signed [X_BITS-1:0] sin_q,
   output logic                     done
);
   import ikm_pkg::*;

   localparam int R_BITS    = WORD_BITS + 1;
   localparam int RED_STEPS = (WORD_BITS > FRAC_BITS) ? WORD_BITS - FRAC_BITS + 1 : 1;
   localparam int STEP_BITS = $clog2((FRAC_BITS > RED_STEPS) ? FRAC_BITS : RED_STEPS);
   localparam int IDX_BITS  = $clog2(FRAC_BITS);
   localparam int WIDE_BITS = WORD_BITS + FRAC_BITS + 4;
   localparam int ZF_BITS   = (WORD_BITS + 3 > FRAC_BITS + 5) ? WORD_BITS + 3 : FRAC_BITS + 5;
   localparam int ZA_BITS   = FRAC_BITS + 4;

   localparam logic [WIDE_BITS-1:0] TWO_PI_W = WIDE_BITS'(to_frac(2 * PI_Q60, FRAC_BITS));
   localparam logic signed [ZF_BITS-1:0] TWO_PI_Z = ZF_BITS'(to_frac(2 * PI_Q60, FRAC_BITS));
   localparam logic signed [ZF_BITS-1:0] PI_Z = ZF_BITS'(to_frac(PI_Q60, FRAC_BITS));
   localparam logic signed [ZF_BITS-1:0] HALF_PI_Z = ZF_BITS'(to_frac(PI_Q60 / 2, FRAC_BITS));
   localparam logic signed [X_BITS-1:0] GAIN_X = X_BITS'(gain_frac(FRAC_BITS));

   ikm_cord_state_type state_ff;
   ikm_cord_state_type state_in;

   logic [FRAC_BITS:0]         atan_tab [FRAC_BITS];
   logic [R_BITS-1:0]          r_ff;
   logic [R_BITS-1:0]          r_in;
   logic                       neg_ff;
   logic                       flip_ff;
   logic                       flip_in;
   logic [STEP_BITS-1:0]       cnt_ff;
   logic [STEP_BITS-1:0]       cnt_in;
   logic signed [X_BITS-1:0]   x_ff;
   logic signed [X_BITS-1:0]   x_in;
   logic signed [X_BITS-1:0]   y_ff;
   logic signed [X_BITS-1:0]   y_in;
   logic signed [ZA_BITS-1:0]  z_ff;
   logic signed [ZA_BITS-1:0]  z_in;
   logic                       done_ff;
   logic                       done_in;
   logic [WIDE_BITS-1:0]       sub;
   logic signed [ZF_BITS-1:0]  z_abs;
   logic signed [ZF_BITS-1:0]  z_s;
   logic signed [ZF_BITS-1:0]  z_w;
   logic signed [ZF_BITS-1:0]  z_f;
   logic signed [X_BITS-1:0]   dx;
   logic signed [X_BITS-1:0]   dy;
   logic signed [ZA_BITS-1:0]  da;
   logic                       red_last;
   logic                       rot_last;

   for (genvar g = 0; g < FRAC_BITS; g++) begin : g_atan
      assign atan_tab[g] = (FRAC_BITS + 1)'(atan_frac(g, FRAC_BITS));
   end

   always_comb begin
      red_last = cnt_ff == '0;
      rot_last = cnt_ff == STEP_BITS'(FRAC_BITS - 1);
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               state_in = CS_REDUCE;
            end
         end
         CS_REDUCE: begin
            if (red_last) begin
               state_in = CS_FOLD;
            end
         end
         CS_FOLD: begin
            state_in = CS_ROTATE;
         end
         CS_ROTATE: begin
            if (rot_last) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      sub     = TWO_PI_W << cnt_ff;
      z_abs   = signed'(ZF_BITS'(r_ff));
      z_s     = neg_ff ? -z_abs : z_abs;
      z_w     = (z_s > PI_Z) ? z_s - TWO_PI_Z : ((z_s < -PI_Z) ? z_s + TWO_PI_Z : z_s);
      flip_in = flip_ff;
      z_f     = z_w;
      if (z_w > HALF_PI_Z) begin
         z_f     = z_w - PI_Z;
         flip_in = 1'b1;
      end else if (z_w < -HALF_PI_Z) begin
         z_f     = z_w + PI_Z;
         flip_in = 1'b1;
      end
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      da      = signed'(ZA_BITS'(atan_tab[cnt_ff[IDX_BITS-1:0]]));
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      done_in = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               r_in   = R_BITS'(angle[T_BITS-1] ? -angle : angle);
               cnt_in = STEP_BITS'(RED_STEPS - 1);
            end
         end
         CS_REDUCE: begin
            if (WIDE_BITS'(r_ff) >= sub) begin
               r_in = r_ff - R_BITS'(sub);
            end
            cnt_in = cnt_ff - 1'b1;
         end
         CS_FOLD: begin
            x_in   = GAIN_X;
            y_in   = '0;
            z_in   = ZA_BITS'(z_f);
            cnt_in = '0;
         end
         CS_ROTATE: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - da;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + da;
            end
            cnt_in  = cnt_ff + 1'b1;
            done_in = rot_last;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (state_ff == CS_IDLE && start) begin
         neg_ff <= angle[T_BITS-1];
      end
      if (reset) begin
         state_ff <= CS_IDLE;
         cnt_ff   <= '0;
         flip_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
         if (state_ff == CS_IDLE && start) begin
            flip_ff <= 1'b0;
         end else if (state_ff == CS_FOLD) begin
            flip_ff <= flip_in;
         end
      end
   end

   assign cos_q = flip_ff ? -x_ff : x_ff;
   assign sin_q = flip_ff ? -y_ff : y_ff;
   assign done  = done_ff;

endmodule

[rtl/core/ikeda_map_iterator.sv]
// ----------------------------------------------------------------------------
// ikeda_map_iterator
// Ikeda map iterator in signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits).
//
// req_if carries one transaction per command: func selects step, load or
// restart; load_x/load_y are used by load only. A step returns the current
// point on rsp_if and then advances it; load and restart return nothing.
// csr_if writes the six map registers by index and is always ready.
// A step transaction is held in the response register from the cycle after
// acceptance. Advancing the point then runs the squares on the shared
// multiplier, the serial divider, angle reduction and the CORDIC stage, and
// the rotation and gain products. The next request is taken once the
// sequencer is idle and the response slot is free or being drained, so a
// stalled receiver holds off further requests. Load and restart write the
// point on acceptance and leave the sequencer idle. Reset restores the
// register defaults and clears the point to the origin.
// ----------------------------------------------------------------------------
module ikeda_map_iterator #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 24
) (
   input logic      clock,
   input logic      reset,
   ikm_req_if.sink  req_if,
   ikm_rsp_if.source rsp_if,
   ikm_csr_if.sink  csr_if
);
   import ikm_pkg::*;

   localparam int MAG_BITS  = (WORD_BITS > FRAC_BITS) ? WORD_BITS + 1 : FRAC_BITS + 1;
   localparam int OP_BITS   = MAG_BITS + 1;
   localparam int PROD_BITS = 2 * MAG_BITS;
   localparam int DEN_BITS  = ((WORD_BITS > FRAC_BITS) ? 2 * WORD_BITS : 2 * FRAC_BITS) + 1;
   localparam int T_BITS    = WORD_BITS + 2;
   localparam int X_BITS    = FRAC_BITS + 3;
   localparam logic [DEN_BITS-1:0] DEN_ONE = DEN_BITS'(1) << (2 * FRAC_BITS);
   localparam logic signed [65:0] WORD_MAX = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
   localparam logic signed [65:0] WORD_MIN = -(66'sd1 <<< (WORD_BITS - 1));

   ikm_state_type state_ff;
   ikm_state_type state_in;

   logic signed [WORD_BITS-1:0] coef_a_ff;
   logic signed [WORD_BITS-1:0] angle_b_ff;
   logic signed [WORD_BITS-1:0] gain_k_ff;
   logic signed [WORD_BITS-1:0] phase_p_ff;
   logic signed [WORD_BITS-1:0] start_x_ff;
   logic signed [WORD_BITS-1:0] start_y_ff;
   logic signed [WORD_BITS-1:0] point_x_ff;
   logic signed [WORD_BITS-1:0] point_y_ff;
   logic signed [WORD_BITS-1:0] point_x_in;
   logic signed [WORD_BITS-1:0] point_y_in;
   logic signed [WORD_BITS-1:0] out_x_ff;
   logic signed [WORD_BITS-1:0] out_y_ff;
   logic                        rsp_valid_ff;
   logic [2:0]                  cnt_ff;
   logic [2:0]                  cnt_in;
   logic [DEN_BITS-1:0]         sqx_ff;
   logic signed [63:0]          res_ff [4];
   logic signed [63:0]          gx_ff;

   logic                        req_fire;
   logic                        step_fire;
   logic signed [OP_BITS-1:0]   op_a;
   logic signed [OP_BITS-1:0]   op_b;
   logic [PROD_BITS-1:0]        prod;
   logic signed [63:0]          prod_q;
   logic                        div_start;
   logic                        div_done;
   logic [WORD_BITS-1:0]        pm;
   logic [WORD_BITS-1:0]        quotient;
   logic [DEN_BITS-1:0]         den;
   logic                        cord_start;
   logic                        cord_done;
   logic signed [T_BITS-1:0]    q_s;
   logic signed [T_BITS-1:0]    t_angle;
   logic signed [X_BITS-1:0]    cos_q;
   logic signed [X_BITS-1:0]    sin_q;
   logic signed [64:0]          u_sum;
   logic signed [64:0]          w_sum;
   logic                        res_we;
   logic [1:0]                  res_idx;
   logic                        gx_we;
   logic                        point_we;

   function automatic logic signed [WORD_BITS-1:0] clamp_word(input logic signed [65:0] v);
      if (v > WORD_MAX) begin
         return WORD_BITS'(WORD_MAX);
      end
      if (v < WORD_MIN) begin
         return WORD_BITS'(WORD_MIN);
      end
      return WORD_BITS'(v);
   endfunction

   ikm_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod),
      .prod_q (prod_q)
   );

   ikm_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pm),
      .divisor  (den),
      .quotient (quotient),
      .done     (div_done)
   );

   ikm_cordic #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .angle (t_angle),
      .cos_q (cos_q),
      .sin_q (sin_q),
      .done  (cord_done)
   );

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire     = req_if.valid && req_if.ready;
   assign step_fire    = req_fire && (req_if.func == FUNC_STEP);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_x = out_x_ff;
   assign rsp_if.out_y = out_y_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (step_fire) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (cnt_ff == 3'd2) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            if (cord_done) begin
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (cnt_ff == 3'd4) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (cnt_ff == 3'd2) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pm         = WORD_BITS'(phase_p_ff[WORD_BITS-1] ? -phase_p_ff : phase_p_ff);
      den        = sqx_ff + DEN_BITS'(prod) + DEN_ONE;
      q_s        = signed'(T_BITS'(quotient));
      q_s        = phase_p_ff[WORD_BITS-1] ? -q_s : q_s;
      t_angle    = T_BITS'(angle_b_ff) - q_s;
      u_sum      = 65'(res_ff[0]) - 65'(res_ff[1]);
      w_sum      = 65'(res_ff[2]) + 65'(res_ff[3]);
      op_a       = OP_BITS'(point_x_ff);
      op_b       = OP_BITS'(point_x_ff);
      div_start  = 1'b0;
      cord_start = 1'b0;
      res_we     = 1'b0;
      res_idx    = cnt_ff[1:0] - 2'd1;
      gx_we      = 1'b0;
      point_we   = 1'b0;
      cnt_in     = cnt_ff + 3'd1;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
         end
         ST_SQR: begin
            if (cnt_ff == 3'd1) begin
               op_a = OP_BITS'(point_y_ff);
               op_b = OP_BITS'(point_y_ff);
            end
            if (cnt_ff == 3'd2) begin
               div_start = 1'b1;
               cnt_in    = '0;
            end
         end
         ST_DIV: begin
            cnt_in     = '0;
            cord_start = div_done;
         end
         ST_TRIG: begin
            cnt_in = '0;
         end
         ST_ROT: begin
            case (cnt_ff)
               3'd0: begin
                  op_a = OP_BITS'(point_x_ff);
                  op_b = OP_BITS'(cos_q);
               end
               3'd1: begin
                  op_a = OP_BITS'(point_y_ff);
                  op_b = OP_BITS'(sin_q);
               end
               3'd2: begin
                  op_a = OP_BITS'(point_x_ff);
                  op_b = OP_BITS'(sin_q);
               end
               default: begin
                  op_a = OP_BITS'(point_y_ff);
                  op_b = OP_BITS'(cos_q);
               end
            endcase
            res_we = cnt_ff != 3'd0;
            if (cnt_ff == 3'd4) begin
               cnt_in = '0;
            end
         end
         ST_GAIN: begin
            op_a     = OP_BITS'(gain_k_ff);
            op_b     = (cnt_ff == 3'd0) ? OP_BITS'(u_sum) : OP_BITS'(w_sum);
            gx_we    = cnt_ff == 3'd1;
            point_we = cnt_ff == 3'd2;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_comb begin
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      if (req_fire && req_if.func == FUNC_LOAD) begin
         point_x_in = req_if.load_x;
         point_y_in = req_if.load_y;
      end else if (req_fire && req_if.func == FUNC_RESTART) begin
         point_x_in = start_x_ff;
         point_y_in = start_y_ff;
      end else if (point_we) begin
         point_x_in = clamp_word(66'(coef_a_ff) + 66'(gx_ff));
         point_y_in = clamp_word(66'(prod_q));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQR && cnt_ff == 3'd1) begin
         sqx_ff <= DEN_BITS'(prod);
      end
      if (res_we) begin
         res_ff[res_idx] <= prod_q;
      end
      if (gx_we) begin
         gx_ff <= prod_q;
      end
      if (step_fire) begin
         out_x_ff <= point_x_ff;
         out_y_ff <= point_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         coef_a_ff    <= WORD_BITS'(signed'(RST_COEF_A));
         angle_b_ff   <= WORD_BITS'(signed'(RST_ANGLE_B));
         gain_k_ff    <= WORD_BITS'(signed'(RST_GAIN_K));
         phase_p_ff   <= WORD_BITS'(signed'(RST_PHASE_P));
         start_x_ff   <= '0;
         start_y_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
         if (step_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               REG_COEF_A:  coef_a_ff  <= csr_if.data;
               REG_ANGLE_B: angle_b_ff <= csr_if.data;
               REG_GAIN_K:  gain_k_ff  <= csr_if.data;
               REG_PHASE_P: phase_p_ff <= csr_if.data;
               REG_START_X: start_x_ff <= csr_if.data;
               REG_START_Y: start_y_ff <= csr_if.data;
               default: begin
                  coef_a_ff <= coef_a_ff;
               end
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> state_ff == ST_IDLE)
      else $error("request taken while sequencer busy");

   a_step_emits: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (rsp_valid_ff && state_ff == ST_SQR))
      else $error("step transaction did not post a response and start");

   a_other_no_emit: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.func != FUNC_STEP && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("load or restart posted a response");

   a_gain_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN && cnt_ff == 3'd2) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after update");
`endif

endmodule
